FILE: src/lpl_pkg.sv
// Shared types and constants for the landmark potential lookup unit.
// No dependencies.
package lpl_pkg;

  localparam logic [31:0] DIST_INF = 32'hffff_ffff;

  typedef enum logic [1:0] {
    ACT_WRITE_KEY  = 2'd0,
    ACT_WRITE_DIST = 2'd1,
    ACT_FORWARD    = 2'd2,
    ACT_BACKWARD   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_ENTRIES   = 2'd0,
    CFG_LANDMARKS = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] entry_index;
    logic [3:0]  landmark_index;
    logic [63:0] node_key;
    logic [63:0] other_key;
    logic [31:0] dist_toward;
    logic [31:0] dist_away;
  } in_word_t;

  typedef struct packed {
    logic [31:0] potential;
    logic        first_found;
    logic        second_found;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PROBE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Fold the difference a - b into best under the infinity rules.
  function automatic logic [31:0] fold(input logic [31:0] best,
                                       input logic [31:0] a,
                                       input logic [31:0] b);
    logic [31:0] d;
    logic        use_d;
    d     = a - b;
    use_d = 1'b0;
    if (b != DIST_INF) begin
      if (a == DIST_INF) begin
        d     = DIST_INF;
        use_d = 1'b1;
      end else if (a > b) begin
        use_d = 1'b1;
      end
    end
    return (use_d && d > best) ? d : best;
  endfunction

endpackage

FILE: src/lpl_key_search.sv
// Key memory with a binary search engine; each probe issues a registered read, then compares.
// Depends on lpl_pkg.
module lpl_key_search
  import lpl_pkg::*;
#(
  parameter int MAX_ENTRIES = 4096,
  parameter int EW = $clog2(MAX_ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [EW-1:0] wr_addr,
  input  logic [63:0]   wr_key,
  input  logic          go,
  input  logic [63:0]   key,
  input  logic [EW:0]   n,
  output logic          done,
  output logic          found,
  output logic [EW-1:0] pos
);

  logic [63:0]   mem [MAX_ENTRIES];
  logic [63:0]   rd_r;
  logic [EW:0]   lo_r, hi_r, lo_nxt, hi_nxt, mid;
  logic          act_r, act_nxt, wait_r, wait_nxt, found_r, found_nxt;
  logic [EW-1:0] pos_r, pos_nxt;
  logic [63:0]   key_r;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_key;
    rd_r <= mem[mid[EW-1:0]];
  end

  // Step the search: issue a read, then compare
  always_comb begin
    lo_nxt = lo_r; hi_nxt = hi_r; act_nxt = act_r; wait_nxt = wait_r;
    found_nxt = found_r; pos_nxt = pos_r;
    done = 1'b0;
    if (go) begin
      lo_nxt = '0; hi_nxt = n; act_nxt = 1'b1; wait_nxt = 1'b0; found_nxt = 1'b0;
    end else if (act_r) begin
      if (!wait_r) begin
        if (lo_r >= hi_r) begin
          act_nxt = 1'b0; done = 1'b1;
        end else begin
          wait_nxt = 1'b1;
        end
      end else begin
        wait_nxt = 1'b0;
        if (rd_r < key_r) lo_nxt = mid + 1'b1;
        else if (rd_r > key_r) hi_nxt = mid;
        else begin
          found_nxt = 1'b1; pos_nxt = mid[EW-1:0]; act_nxt = 1'b0; done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0; wait_r <= 1'b0; found_r <= 1'b0;
    end else begin
      act_r <= act_nxt; wait_r <= wait_nxt; found_r <= found_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; pos_r <= pos_nxt;
    if (go) key_r <= key;
  end

  assign found = found_nxt;
  assign pos   = pos_nxt;

endmodule

FILE: src/lpl_dist_store.sv
// Toward and away distance memories, one registered read per cycle.
// Depends on lpl_pkg.
module lpl_dist_store
  import lpl_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_toward,
  input  logic [31:0]   wr_away,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_toward,
  output logic [31:0]   rd_away
);

  logic [31:0] toward_mem [DEPTH];
  logic [31:0] away_mem [DEPTH];

  // Write both stores together; read registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      toward_mem[wr_addr] <= wr_toward;
      away_mem[wr_addr]   <= wr_away;
    end
    rd_toward <= toward_mem[rd_addr];
    rd_away   <= away_mem[rd_addr];
  end

endmodule

FILE: src/landmark_potential_lookup_unit.sv
// Top level of the landmark potential lookup unit.
// Depends on lpl_pkg, lpl_key_search and lpl_dist_store.
//
// Usage:
//   Input words arrive on in_word with in_start; a word is taken when
//   in_start is high and in_busy is low. Actions 0 and 1 write a key or a
//   landmark distance pair; actions 2 and 3 query a forward or backward
//   potential for node_key against other_key.
//   Every word gives one result word on out_word, marked by out_valid for
//   exactly one cycle; the receiver cannot stall it.
//   A write strobes its result in the cycle after it is taken.
//   A query runs two binary searches on the single key memory port, one
//   after the other, each a start step and then its probes, then scans the
//   landmarks in use from the one distance port with two reads per
//   landmark, then drains the last read and strobes the result. One word
//   is in flight at a time; the next word is taken no earlier than the
//   cycle after the strobe.
//   Configuration: cfg_we, cfg_index, cfg_data; writes take effect at once.
//   Reset: rst_n synchronous, active low; entries_in_use clears to 0 and
//   landmarks_in_use to 1. Table contents are undefined until written.
module landmark_potential_lookup_unit
  import lpl_pkg::*;
#(
  parameter int MAX_ENTRIES   = 4096,
  parameter int MAX_LANDMARKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  input  in_word_t    in_word,
  output logic        in_busy,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int LW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int AW = EW + LW;

  state_t      state_r, state_nxt;
  in_word_t    cmd_r;
  logic [EW:0] ent_r;
  logic [LW:0] lmk_r;
  logic        uf_r, of_r, second_r;
  logic [EW-1:0] upos_r, opos_r;
  logic [LW:0] li_r;
  logic        rd_other_r, rd_v_r;
  logic [31:0] tu_r, fu_r, best_r;
  logic        go, sdone, sfound;
  logic [EW-1:0] spos;
  logic [31:0] rt, ra, tu, to, fu, fo, b1;
  logic        accept;

  assign accept  = in_start && state_r == ST_IDLE;
  assign in_busy = state_r != ST_IDLE;

  // Configuration registers, saturated on write; the landmark count uses only cfg_data[4:0]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
      lmk_r <= LW'(1) + (LW+1)'(0);
    end else if (cfg_we) begin
      if (cfg_index == 1'(CFG_ENTRIES))
        ent_r <= (32'(cfg_data) > 32'(MAX_ENTRIES)) ? (EW+1)'(MAX_ENTRIES)
                                                    : (EW+1)'(cfg_data);
      else
        lmk_r <= (32'(cfg_data[4:0]) > 32'(MAX_LANDMARKS)) ? (LW+1)'(MAX_LANDMARKS)
                                                          : (LW+1)'(cfg_data[4:0]);
    end
  end

  logic kw, dw;
  assign kw = accept && in_word.action == ACT_WRITE_KEY
              && 32'(in_word.entry_index) < 32'(MAX_ENTRIES);
  assign dw = accept && in_word.action == ACT_WRITE_DIST
              && 32'(in_word.entry_index) < 32'(MAX_ENTRIES)
              && 32'(in_word.landmark_index) < 32'(MAX_LANDMARKS);

  lpl_key_search #(.MAX_ENTRIES(MAX_ENTRIES), .EW(EW)) u_search (
    .clk, .rst_n,
    .wr_en(kw), .wr_addr(EW'(in_word.entry_index)), .wr_key(in_word.node_key),
    .go, .key(second_r ? cmd_r.other_key : cmd_r.node_key), .n(ent_r),
    .done(sdone), .found(sfound), .pos(spos)
  );

  logic [AW-1:0] rd_addr;
  assign rd_addr = {(rd_other_r ? opos_r : upos_r), li_r[LW-1:0]};

  lpl_dist_store #(.DEPTH(MAX_ENTRIES << LW), .AW(AW)) u_dist (
    .clk,
    .wr_en(dw),
    .wr_addr({EW'(in_word.entry_index), LW'(in_word.landmark_index)}),
    .wr_toward(in_word.dist_toward), .wr_away(in_word.dist_away),
    .rd_addr, .rd_toward(rt), .rd_away(ra)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = in_word.action[1] ? ST_SEARCH : ST_DONE;
      ST_SEARCH: state_nxt = ST_PROBE;
      ST_PROBE:  if (sdone && second_r) state_nxt = ST_SCAN;
                 else if (sdone) state_nxt = ST_SEARCH;
      ST_SCAN:   if (li_r >= lmk_r) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign go = state_r == ST_SEARCH;

  // Missing nodes read as infinity
  assign tu = uf_r ? tu_r : DIST_INF;
  assign fu = uf_r ? fu_r : DIST_INF;
  assign to = of_r ? rt : DIST_INF;
  assign fo = of_r ? ra : DIST_INF;
  assign b1 = (cmd_r.action == ACT_FORWARD) ? fold(fold(best_r, tu, to), fo, fu)
                                             : fold(fold(best_r, to, tu), fu, fo);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= state_r == ST_SCAN && li_r < lmk_r;
    end
    if (accept) begin
      cmd_r <= in_word; second_r <= 1'b0; best_r <= '0;
      uf_r <= 1'b0; of_r <= 1'b0;
    end
    if (state_r == ST_PROBE && sdone) begin
      if (second_r) begin
        of_r <= sfound; opos_r <= spos;
      end else begin
        uf_r <= sfound; upos_r <= spos;
      end
      second_r <= 1'b1;
      li_r <= '0; rd_other_r <= 1'b0;
    end
    // Alternate reads: node u, then other node, for each landmark
    if (state_r == ST_SCAN) begin
      rd_other_r <= !rd_other_r;
      if (rd_other_r) li_r <= li_r + 1'b1;
    end
    // Read select has already toggled past the read whose data lands now
    if (rd_v_r) begin
      if (rd_other_r) begin
        tu_r <= rt; fu_r <= ra;
      end else begin
        best_r <= b1;
      end
    end
  end

  // Result word
  always_comb begin
    out_valid = state_r == ST_DONE;
    out_word.potential    = cmd_r.action[1] ? best_r : '0;
    out_word.first_found  = cmd_r.action[1] & uf_r;
    out_word.second_found = cmd_r.action[1] & of_r;
  end

endmodule

FILE: src/lpl_checker.sv
// Port-level checks for the landmark potential lookup unit.
// Depends on lpl_pkg; bound to landmark_potential_lookup_unit.
module lpl_checker
  import lpl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_start,
  input logic      in_busy,
  input logic      out_valid
);

  // A taken word makes the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_start && !in_busy |=> in_busy) else $error("busy not raised");

  // A result ends the busy period
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !in_busy) else $error("busy after result");

  // Results come only while busy
  a_vbusy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_busy) else $error("result while idle");

  // Hold each result for one cycle only
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result longer than one cycle");

endmodule

bind landmark_potential_lookup_unit lpl_checker u_lpl_checker (
  .clk, .rst_n, .in_start, .in_busy, .out_valid
);
